[hdl/frac_n_pll_divider_plan_unit_macros.svh]
// Assertion macros for the fractional-N divider planner.
`ifndef FRAC_N_PLL_DIVIDER_PLAN_UNIT_MACROS_SVH
`define FRAC_N_PLL_DIVIDER_PLAN_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define FNPLL_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define FNPLL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FNPLL_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define FNPLL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

[hdl/fnpll_pkg.sv]
// Types and constants for the fractional-N divider planner.
package fnpll_pkg;

    localparam int FREQ_W    = 23;
    localparam int REF_W     = 18;
    localparam int MOD_W     = 12;
    localparam int INT_W     = 16;
    localparam int FRAC_W    = 12;
    localparam int SEL_W     = 3;
    localparam int PROD_W    = REF_W + MOD_W;
    localparam int STEP_W    = 5;

    localparam logic [FREQ_W-1:0] CUTOFF_KHZ  = 23'd2200000;
    localparam logic [SEL_W-1:0]  MAX_DIV_SEL = 3'd6;
    localparam logic [STEP_W-1:0] INT_STEPS   = 5'd23;
    localparam logic [STEP_W-1:0] FRAC_STEPS  = 5'd12;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 12'd2500;
    localparam logic [REF_W-1:0] REF_RESET     = 18'd25000;

    typedef enum logic
    {
        CFG_MODULUS,
        CFG_REF_FREQ
    } cfg_index_t;

endpackage

[hdl/frac_n_pll_divider_plan_unit.sv]
// Fractional-N synthesizer divider planner: divider select, INT and FRAC from a frequency.
//
// One request (start while not busy) gives one result, shown for exactly one cycle with
// done; the receiver cannot stall it, so capture it on that edge. A zero frequency or a
// zero reference answers in the cycle after start with error set. A frequency that would
// need a divider select above 6, and an INT overflow, both answer with error set. Otherwise
// the result follows the divider search, the INT division (23 quotient bits), the multiply
// state, the load state and the FRAC division (12 quotient bits), in that order. One 23-bit
// subtractor is shared by the search compare and both restoring divisions. busy stays
// high until the cycle that done is shown; a new request may be given in that cycle.
// Register writes are taken only while idle and no start is present.
`include "frac_n_pll_divider_plan_unit_macros.svh"

module frac_n_pll_divider_plan_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [fnpll_pkg::FREQ_W-1:0]        freq_khz,
    output logic                                done,
    output logic [fnpll_pkg::INT_W-1:0]         int_value,
    output logic [fnpll_pkg::FRAC_W-1:0]        frac_value,
    output logic [fnpll_pkg::SEL_W-1:0]         divider_select,
    output logic                                error,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  fnpll_pkg::cfg_index_t               cfg_index,
    input  logic [fnpll_pkg::REF_W-1:0]         cfg_data
);

    import fnpll_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_DIV_INT,
        ST_MUL,
        ST_LOAD_FRAC,
        ST_DIV_FRAC
    } state_t;

    state_t              state_reg, state_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                error_reg, error_next;
    logic [INT_W-1:0]    int_reg, int_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [SEL_W-1:0]    sel_reg, sel_next;
    logic [MOD_W-1:0]    modulus_reg, modulus_next;
    logic [REF_W-1:0]    ref_reg, ref_next;

    logic [FREQ_W-1:0]   freq_sh_reg, freq_sh_next;
    logic [FREQ_W-1:0]   dq_reg, dq_next;
    logic [REF_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [INT_W-1:0]    int_hold_reg, int_hold_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic                accept;
    logic                cfg_write;
    logic [REF_W:0]      trial;
    logic [FREQ_W-1:0]   sub_a;
    logic [FREQ_W-1:0]   sub_b;
    logic [FREQ_W:0]     diff;
    logic                borrow;

    assign accept    = start && !busy_reg;
    assign cfg_ready = !busy_reg && !start;
    assign cfg_write = cfg_valid && cfg_ready;

    // Shared subtractor: search compare against the cutoff, or a division trial step.
    assign trial = {rem_reg, dq_reg[FREQ_W-1]};

    always_comb
    begin
        case (state_reg)
            ST_SEARCH:
            begin
                sub_a = CUTOFF_KHZ;
                sub_b = freq_sh_reg;
            end
            default:
            begin
                sub_a = FREQ_W'(trial);
                sub_b = FREQ_W'(ref_reg);
            end
        endcase
    end

    assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = diff[FREQ_W];

    always_comb
    begin
        state_next    = state_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        error_next    = error_reg;
        int_next      = int_reg;
        frac_next     = frac_reg;
        sel_next      = sel_reg;
        modulus_next  = modulus_reg;
        ref_next      = ref_reg;
        freq_sh_next  = freq_sh_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        int_hold_next = int_hold_reg;
        prod_next     = prod_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODULUS:  modulus_next = cfg_data[MOD_W-1:0];
                CFG_REF_FREQ: ref_next     = cfg_data;
                default:      ref_next     = ref_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    freq_sh_next = freq_khz;
                    sel_next     = '0;
                    if (freq_khz == '0 || ref_reg == '0)
                    begin
                        done_next  = 1'b1;
                        error_next = 1'b1;
                        int_next   = '0;
                        frac_next  = '0;
                    end
                    else
                    begin
                        busy_next  = 1'b1;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                // Stop at the first shift that puts the frequency above the cutoff.
                if (borrow)
                begin
                    dq_next    = freq_sh_reg;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV_INT;
                end
                else if (sel_reg == MAX_DIV_SEL)
                begin
                    done_next  = 1'b1;
                    error_next = 1'b1;
                    busy_next  = 1'b0;
                    int_next   = '0;
                    frac_next  = '0;
                    sel_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    freq_sh_next = {freq_sh_reg[FREQ_W-2:0], 1'b0};
                    sel_next     = sel_reg + 1'b1;
                end
            end
            ST_DIV_INT, ST_DIV_FRAC:
            begin
                rem_next  = borrow ? trial[REF_W-1:0] : diff[REF_W-1:0];
                dq_next   = {dq_reg[FREQ_W-2:0], !borrow};
                step_next = step_reg + 1'b1;
                if (state_reg == ST_DIV_INT && step_reg == INT_STEPS - 1'b1)
                begin
                    state_next = ST_MUL;
                end
                else if (state_reg == ST_DIV_FRAC && step_reg == FRAC_STEPS - 1'b1)
                begin
                    done_next  = 1'b1;
                    error_next = 1'b0;
                    busy_next  = 1'b0;
                    int_next   = int_hold_reg;
                    frac_next  = dq_next[FRAC_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                if (dq_reg[FREQ_W-1:INT_W] != '0)
                begin
                    done_next  = 1'b1;
                    error_next = 1'b1;
                    busy_next  = 1'b0;
                    int_next   = '0;
                    frac_next  = '0;
                    sel_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    int_hold_next = dq_reg[INT_W-1:0];
                    prod_next     = PROD_W'(rem_reg) * PROD_W'(modulus_reg);
                    state_next    = ST_LOAD_FRAC;
                end
            end
            ST_LOAD_FRAC:
            begin
                // The product's upper part is already below the reference.
                rem_next   = prod_reg[PROD_W-1:FRAC_W];
                dq_next    = {prod_reg[FRAC_W-1:0], (FREQ_W-FRAC_W)'(0)};
                step_next  = '0;
                state_next = ST_DIV_FRAC;
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            error_reg   <= 1'b0;
            int_reg     <= '0;
            frac_reg    <= '0;
            sel_reg     <= '0;
            modulus_reg <= MODULUS_RESET;
            ref_reg     <= REF_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            error_reg   <= error_next;
            int_reg     <= int_next;
            frac_reg    <= frac_next;
            sel_reg     <= sel_next;
            modulus_reg <= modulus_next;
            ref_reg     <= ref_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_sh_reg  <= freq_sh_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        int_hold_reg <= int_hold_next;
        prod_reg     <= prod_next;
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign error          = error_reg;
    assign int_value      = int_reg;
    assign frac_value     = frac_reg;
    assign divider_select = sel_reg;

    `FNPLL_ASSERT(a_done_not_busy, clk, rst_n, done |-> !busy, "done while still busy")
    `FNPLL_ASSERT(a_error_zero, clk, rst_n, (done && error) |-> (int_value == '0 && frac_value == '0 && divider_select == '0), "error result carries nonzero fields")
    `FNPLL_ASSERT(a_result_range, clk, rst_n, (done && !error) |-> (divider_select <= MAX_DIV_SEL && (frac_value < modulus_reg || modulus_reg == '0)), "result out of range")
    `FNPLL_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done, "request neither started nor answered")
    `FNPLL_ASSERT(a_rem_below_ref, clk, rst_n, (state_reg == ST_DIV_INT || state_reg == ST_DIV_FRAC) |-> (rem_reg < ref_reg), "division remainder not below reference")

endmodule
